/* design/assert_macros.svh */
// assertion macros used by the set table sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define AST_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define AST_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AST_ASSERT(name, clk, rst_n, prop, msg)

`define AST_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

/* design/ast_pkg.sv */
// types and constants of the set table
package ast_pkg;

	localparam int CAPACITY   = 64;
	localparam int ELEM_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	localparam logic STS_DONE = 1'b0;
	localparam logic STS_FULL = 1'b1;

	typedef struct packed {
		logic             was_member;
		logic             status;
		logic [CNT_W-1:0] count_after;
		logic             is_empty;
		logic             is_full;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [ELEM_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} mem_req_t;

endpackage

/* design/ast_req_if.sv */
// request channel of the set table
interface ast_req_if
	import ast_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

/* design/ast_rsp_if.sv */
// result channel of the set table
interface ast_rsp_if
	import ast_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             was_member;
	logic             status;
	logic [CNT_W-1:0] count_after;
	logic             is_empty;
	logic             is_full;

	modport source (output valid, output was_member, output status, output count_after,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input was_member, input status, input count_after,
		input is_empty, input is_full, output ready);
endinterface

/* design/ast_ram.sv */
// simple dual-port ram, one write and one registered read per cycle
module ast_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/ast_ctrl.sv */
// request sequencer: search, append and compaction over the entry ram
`include "assert_macros.svh"

module ast_ctrl
	import ast_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ast_req_if.sink               req,
	output mem_req_t              mem_req,
	input  logic [ELEM_WIDTH-1:0] rdata,
	output logic                  res_valid,
	output result_t               res,
	input  logic                  res_ready
);
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_SHIFT  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t                state_q;
	logic [1:0]            action_q;
	logic [ELEM_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      issue_idx_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  found_q;
	logic                  status_q;

	logic match;
	logic issue_left;
	logic has_room;
	logic search_miss;
	logic is_insert;
	logic is_delete;

	assign is_insert   = action_q == ACT_INSERT;
	assign is_delete   = action_q == ACT_DELETE;
	assign match       = rd_vld_s1 && (rdata == value_q);
	assign issue_left  = issue_idx_q != count_q;
	assign has_room    = count_q != CNT_W'(CAPACITY);
	assign search_miss = !match && !issue_left && !rd_vld_s1;

	assign req.ready = state_q == ST_IDLE;

	always_comb begin
		mem_req       = '0;
		mem_req.raddr = issue_idx_q[IDX_W-1:0];
		mem_req.waddr = count_q[IDX_W-1:0];
		mem_req.wdata = value_q;
		unique case (state_q)
			ST_SEARCH: begin
				mem_req.re = !match && issue_left;
				// append a new value at the end of the array
				mem_req.we = search_miss && is_insert && has_room;
			end
			ST_SHIFT: begin
				mem_req.re    = issue_left;
				// entry read last cycle moves down one place
				mem_req.we    = rd_vld_s1;
				mem_req.waddr = idx_s1 - IDX_W'(1);
				mem_req.wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			status_q    <= STS_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						issue_idx_q <= '0;
						rd_vld_s1   <= 1'b0;
						state_q     <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (match) begin
						found_q   <= 1'b1;
						status_q  <= STS_DONE;
						rd_vld_s1 <= 1'b0;
						if (is_delete) begin
							issue_idx_q <= CNT_W'(idx_s1) + CNT_W'(1);
							state_q     <= ST_SHIFT;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (search_miss) begin
						found_q  <= 1'b0;
						status_q <= (is_insert && !has_room) ? STS_FULL : STS_DONE;
						if (is_insert && has_room) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_DONE;
					end else begin
						rd_vld_s1 <= issue_left;
						if (issue_left) begin
							issue_idx_q <= issue_idx_q + CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					rd_vld_s1 <= issue_left;
					if (issue_left) begin
						issue_idx_q <= issue_idx_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_q <= req.action;
			value_q  <= req.value[ELEM_WIDTH-1:0];
		end
		if (issue_left && (state_q == ST_SHIFT || (state_q == ST_SEARCH && !match))) begin
			idx_s1 <= issue_idx_q[IDX_W-1:0];
		end
	end

	assign res_valid       = state_q == ST_DONE;
	assign res.was_member  = found_q;
	assign res.status      = status_q;
	assign res.count_after = count_q;
	assign res.is_empty    = count_q == '0;
	assign res.is_full     = count_q == CNT_W'(CAPACITY);

	`AST_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY),
		"fill count beyond capacity")
	`AST_ASSERT(a_read_in_range, clk, arst_n,
		mem_req.re |-> (CNT_W'(mem_req.raddr) < count_q), "read beyond filled entries")
	`AST_ASSERT(a_shift_write_in_range, clk, arst_n,
		(mem_req.we && state_q == ST_SHIFT) |-> (CNT_W'(mem_req.waddr) + CNT_W'(1) < count_q),
		"compaction write beyond filled entries")
	`AST_ASSERT(a_accept_starts_search, clk, arst_n,
		(req.valid && req.ready) |=> (state_q == ST_SEARCH), "accepted request did not start search")
	`AST_NEVER(a_write_during_read_search, clk, arst_n,
		state_q == ST_SEARCH && mem_req.we && mem_req.re, "append overlaps a search read")
endmodule

/* design/array_set_table_core.sv */
// top level of the set table: sequencer, entry ram and result register
// Set of up to 64 distinct 32-bit values held in a single simple dual-port
// ram with a fill count. One request is in work at a time. The ram's single
// read port sets the pace: a request is taken, the stored entries are
// scanned in order until a hit or the end, and the result is handed over;
// a delete that hits at position p then moves each later entry down one
// place, starting where the search stopped. A finished result waits in an
// output register so the next request is taken while it is still unclaimed.
// No clearing pass runs after reset: only entries below the fill count are
// ever read.
module array_set_table_core
	import ast_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ast_req_if.sink   req,
	ast_rsp_if.source rsp
);
	mem_req_t              mem_req;
	logic [ELEM_WIDTH-1:0] rdata;
	logic                  res_valid;
	result_t               res;
	logic                  res_ready;
	logic                  rsp_valid_q;
	result_t               rsp_q;

	ast_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	ast_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ELEM_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// result register frees up once the current result is taken
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.was_member  = rsp_q.was_member;
	assign rsp.status      = rsp_q.status;
	assign rsp.count_after = rsp_q.count_after;
	assign rsp.is_empty    = rsp_q.is_empty;
	assign rsp.is_full     = rsp_q.is_full;
endmodule

/* sim/ast_result_checker.sv */
// checker for the set table: tracks the set, predicts each result and compares
`timescale 1ns / 1ps

module ast_result_checker
	import ast_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ast_req_if   req,
	ast_rsp_if   rsp,
	output int   outstanding,
	output int   fail_count
);

	logic [ELEM_WIDTH-1:0] set_entries [CAPACITY];
	int                    set_fill;
	result_t               expected_results [$];

	// updates the tracked set for one request and returns the result it must give
	function automatic result_t apply_request(input logic [1:0] act,
		input logic [VALUE_W-1:0] val);
		logic [ELEM_WIDTH-1:0] elem;
		int                    hit_pos;
		result_t               res;
		elem = val[ELEM_WIDTH-1:0];
		hit_pos = -1;
		for (int i = 0; i < set_fill; i++) begin
			if (hit_pos < 0 && set_entries[i] == elem)
				hit_pos = i;
		end
		res = '0;
		res.was_member = (hit_pos >= 0);
		res.status = STS_DONE;
		case (action_t'(act))
			ACT_INSERT: begin
				if (hit_pos < 0) begin
					if (set_fill >= CAPACITY) begin
						res.status = STS_FULL;
					end else begin
						set_entries[set_fill] = elem;
						set_fill++;
					end
				end
			end
			ACT_DELETE: begin
				if (hit_pos >= 0) begin
					// later entries close the gap
					for (int j = hit_pos; j < set_fill - 1; j++)
						set_entries[j] = set_entries[j + 1];
					set_fill--;
				end
			end
			default: begin
			end
		endcase
		res.count_after = set_fill[CNT_W-1:0];
		res.is_empty = (set_fill == 0);
		res.is_full = (set_fill == CAPACITY);
		return res;
	endfunction

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			set_fill = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// results leave before a request taken on the same edge can finish
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, actual %0d/%0d/%0d/%0d/%0d",
						$realtime, rsp.was_member, rsp.status, rsp.count_after,
						rsp.is_empty, rsp.is_full);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("was_member", want.was_member, rsp.was_member);
					compare_field("status", want.status, rsp.status);
					compare_field("count_after", want.count_after, rsp.count_after);
					compare_field("is_empty", want.is_empty, rsp.is_empty);
					compare_field("is_full", want.is_full, rsp.is_full);
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_request(req.action, req.value));
			outstanding <= expected_results.size();
		end
	end

endmodule

/* sim/tb_array_set_table_core.sv */
// testbench top for the set table: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_array_set_table_core;
	import ast_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int         ITEM_TARGET = 850;
	localparam int         POOL_SIZE   = 96;
	localparam int         IDLE_PCT    = 29;
	localparam int         SETTLE      = 140;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   sent;
	int   outstanding;
	int   fail_count;

	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	ast_req_if req_ch ();
	ast_rsp_if rsp_ch ();

	array_set_table_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	ast_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.outstanding(outstanding),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side stalls at random outside the no-idle stretch
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_request(input logic [1:0] act, input logic [VALUE_W-1:0] val);
		no_idle = (sent >= 400 && sent < 560);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.value  <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(99) < 10)
			return $urandom;
		return value_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	initial begin
		int         kind;
		int         seg_len;
		int         roll;
		logic [1:0] act;
		arst_n        = 1'b0;
		no_idle       = 1'b0;
		sent          = 0;
		req_ch.valid  = 1'b0;
		req_ch.action = ACT_INSERT;
		req_ch.value  = '0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, extremes, duplicates, unused code, absent and present deletes
		send_request(ACT_QUERY, 32'd5);
		send_request(ACT_DELETE, 32'd5);
		send_request(ACT_INSERT, 32'h0000_0000);
		send_request(ACT_INSERT, 32'h0000_0000);
		send_request(ACT_INSERT, 32'hFFFF_FFFF);
		send_request(ACT_QUERY, 32'hFFFF_FFFF);
		send_request(ACT_UNUSED, 32'h0000_0000);
		send_request(ACT_UNUSED, 32'h1234_5678);
		send_request(ACT_DELETE, 32'h0001_2345);
		send_request(ACT_INSERT, 32'hA5A5_A5A5);
		send_request(ACT_INSERT, 32'h5A5A_5A5A);
		send_request(ACT_DELETE, 32'h0000_0000);
		send_request(ACT_DELETE, 32'h5A5A_5A5A);
		send_request(ACT_QUERY, 32'h0000_0000);
		send_request(ACT_DELETE, 32'hFFFF_FFFF);
		send_request(ACT_DELETE, 32'hA5A5_A5A5);
		wait_all_results();

		// fill to capacity, then refusal, duplicate when full and worst-case shift
		for (int i = 0; i < CAPACITY; i++)
			send_request(ACT_INSERT, value_pool[i]);
		send_request(ACT_INSERT, value_pool[CAPACITY]);
		send_request(ACT_INSERT, value_pool[3]);
		send_request(ACT_QUERY, value_pool[CAPACITY - 1]);
		send_request(ACT_UNUSED, value_pool[CAPACITY]);
		send_request(ACT_DELETE, value_pool[0]);
		send_request(ACT_INSERT, value_pool[CAPACITY]);
		send_request(ACT_DELETE, value_pool[CAPACITY]);

		// segments that grow, shrink or churn the set, mostly with pool values
		while (sent < ITEM_TARGET) begin
			kind = $urandom_range(2);
			seg_len = $urandom_range(20, 120);
			for (int k = 0; k < seg_len && sent < ITEM_TARGET; k++) begin
				roll = $urandom_range(99);
				if (roll < 3)
					act = ACT_UNUSED;
				else if (roll < (kind == 0 ? 78 : kind == 1 ? 28 : 48))
					act = ACT_INSERT;
				else if (roll < (kind == 0 ? 90 : 90))
					act = ACT_DELETE;
				else
					act = ACT_QUERY;
				send_request(act, pick_value());
			end
			if ($urandom_range(3) == 0)
				wait_all_results();
		end

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
